// ===== hw/rtl/gauss_jordan_matrix_inverse_top_assert.svh =====
// ----------------------------------------------------------------------------
// gauss-jordan inverter assertion macros
// shared property forms for the top level checks
// ----------------------------------------------------------------------------
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_TOP_ASSERT_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GJMI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gjmi same-cycle check failed");

// next-cycle implication, checked out of reset
`define GJMI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gjmi next-cycle check failed");

`endif

// ===== hw/rtl/gjmi_pkg.sv =====
// ----------------------------------------------------------------------------
// gjmi_pkg
// shared types, constants and helpers of the gauss-jordan inverter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gjmi_pkg;

  localparam int MAX_ORDER_DEF = 8;

  localparam logic [31:0] FX_ONE  = 32'h0001_0000;
  localparam logic [31:0] FX_ZERO = 32'h0000_0000;
  localparam logic [31:0] FX_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] FX_MIN  = 32'h8000_0000;

  localparam logic [3:0]  SIZE_RESET = 4'd8;
  localparam logic [15:0] THR_RESET  = 16'd1;

  // configuration register indexes
  localparam logic REG_MATRIX_SIZE     = 1'b0;
  localparam logic REG_SMALL_THRESHOLD = 1'b1;

  // matrix select inside the shared memory
  localparam logic MAT_WORK = 1'b0;
  localparam logic MAT_INV  = 1'b1;

  // quotient bits of the q16.16 divide
  localparam int DIV_BITS = 48;

  typedef enum logic [2:0] {
    WS_INPUT,
    WS_ZERO,
    WS_ONE,
    WS_A,
    WS_B,
    WS_ELIM,
    WS_DIV
  } wsrc_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsrc_t wr_src;
    logic  cap_a;
    logic  cap_b;
    logic  cap_piv;
    logic  cap_m;
    logic  mul;
    logic  div_start;
    logic  cap_out;
    logic  clr_flags;
    logic  set_sing;
  } cmd_t;

  typedef struct packed {
    logic below_thr;
    logic div_busy;
  } status_t;

  // magnitude of a signed 32-bit value, as unsigned
  function automatic logic [31:0] mag32(logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gjmi_dp.sv =====
// ----------------------------------------------------------------------------
// gjmi_dp
// matrix memory, pivot test, multiply-subtract and serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gjmi_dp import gjmi_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  localparam int RW = $clog2(MAX_ORDER),
  localparam int AW = 2 * RW + 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [31:0] element_value,
  input  wire cmd_t               cmd,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [AW-1:0]      wr_addr,
  output status_t                 status,
  output logic signed [31:0]      inverse_value,
  output logic                    singular_found,
  output logic                    saturated
);

  localparam int DEPTH = 1 << AW;
  localparam int CNTW  = $clog2(DIV_BITS + 1);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic [15:0] small_threshold;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] piv;
  logic [31:0] mult;
  logic signed [63:0] prod;

  // divider
  logic [DIV_BITS-1:0] dq;
  logic [31:0]         drem;
  logic [31:0]         dsor;
  logic [CNTW-1:0]     dcnt;
  logic                dneg;
  logic                dbusy;
  logic [33:0]         trial;

  logic [49:0] elim_diff;
  logic        elim_sat;
  logic [31:0] elim_val;
  logic        div_sat;
  logic [31:0] div_val;
  logic [31:0] wdata;
  logic        wsat;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_threshold <= THR_RESET;
    end else if (cfg_write && cfg_index == REG_SMALL_THRESHOLD) begin
      small_threshold <= cfg_data;
    end
  end

  assign status.below_thr = mag32(rdata) <= {16'd0, small_threshold};
  assign status.div_busy  = dbusy;

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.cap_a)   op_a <= rdata;
    if (cmd.cap_b)   op_b <= rdata;
    if (cmd.cap_piv) piv  <= rdata;
    if (cmd.cap_m)   mult <= rdata;
    if (cmd.mul)     prod <= $signed(mult) * $signed(rdata);
    if (cmd.cap_out) inverse_value <= rdata;
  end

  // v - floor(m*p / 2^16), then clamp
  always_comb begin
    elim_diff = {{18{op_a[31]}}, op_a} - {{2{prod[63]}}, prod[63:16]};
    elim_sat  = !((&elim_diff[49:31]) || !(|elim_diff[49:31]));
    if (!elim_sat) begin
      elim_val = elim_diff[31:0];
    end else if (elim_diff[49]) begin
      elim_val = FX_MIN;
    end else begin
      elim_val = FX_MAX;
    end
  end

  // restoring divide of |a|*2^16 by |pivot|, one quotient bit a cycle
  assign trial = {1'b0, drem, dq[DIV_BITS-1]} - {2'b00, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == CNTW'(1)) begin
      dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= {mag32(rdata), 16'd0};
      drem <= '0;
      dsor <= mag32(piv);
      dneg <= rdata[31] ^ piv[31];
      dcnt <= CNTW'(DIV_BITS);
    end else if (dbusy) begin
      dcnt <= dcnt - CNTW'(1);
      if (!trial[33]) begin
        drem <= trial[31:0];
        dq   <= {dq[DIV_BITS-2:0], 1'b1};
      end else begin
        drem <= {drem[30:0], dq[DIV_BITS-1]};
        dq   <= {dq[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dneg) begin
      div_sat = (|dq[DIV_BITS-1:32]) || (dq[31] && (|dq[30:0]));
      div_val = div_sat ? FX_MIN : (~dq[31:0] + 32'd1);
    end else begin
      div_sat = |dq[DIV_BITS-1:31];
      div_val = div_sat ? FX_MAX : dq[31:0];
    end
  end

  always_comb begin
    wsat = 1'b0;
    case (cmd.wr_src)
      WS_INPUT: wdata = element_value;
      WS_ZERO:  wdata = FX_ZERO;
      WS_ONE:   wdata = FX_ONE;
      WS_A:     wdata = op_a;
      WS_B:     wdata = op_b;
      WS_ELIM: begin
        wdata = elim_val;
        wsat  = elim_sat;
      end
      WS_DIV: begin
        wdata = div_val;
        wsat  = div_sat;
      end
      default:  wdata = FX_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_flags) begin
      singular_found <= 1'b0;
      saturated      <= 1'b0;
    end else begin
      if (cmd.set_sing) singular_found <= 1'b1;
      if (cmd.wr_en && wsat) saturated <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gjmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// gjmi_ctrl
// sequencer for load, pivoting, normalize, elimination and readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gjmi_ctrl import gjmi_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  localparam int RW = $clog2(MAX_ORDER),
  localparam int CW = $clog2(MAX_ORDER + 1),
  localparam int AW = 2 * RW + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               last_of_matrix,
  output cmd_t               cmd,
  input  wire status_t       status,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      wr_addr
);

  typedef enum logic [22:0] {
    S_LOAD  = 23'h000001,
    S_INIT  = 23'h000002,
    S_PRD   = 23'h000004,
    S_PCHK  = 23'h000008,
    S_SRD   = 23'h000010,
    S_SCHK  = 23'h000020,
    S_SWRA  = 23'h000040,
    S_SWRB  = 23'h000080,
    S_SWWA  = 23'h000100,
    S_SWWB  = 23'h000200,
    S_NRD   = 23'h000400,
    S_NCHK  = 23'h000800,
    S_NDIV  = 23'h001000,
    S_NWR   = 23'h002000,
    S_MRD   = 23'h004000,
    S_MCAP  = 23'h008000,
    S_ERV   = 23'h010000,
    S_ERP   = 23'h020000,
    S_EMUL  = 23'h040000,
    S_EWR   = 23'h080000,
    S_ORD   = 23'h100000,
    S_OCAP  = 23'h200000,
    S_OSHOW = 23'h400000
  } state_t;

  state_t        state;
  logic [3:0]    size_reg;
  logic [CW-1:0] n;
  logic [CW-1:0] c;
  logic [CW-1:0] r;
  logic [CW-1:0] k;
  logic          sel;
  logic          back;
  logic          usable;

  logic          rd_sel;
  logic [CW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic          wr_sel;
  logic [CW-1:0] wr_row;
  logic [CW-1:0] wr_col;
  logic          k_last;
  logic          r_last;
  logic          diag;

  // effective order: zero acts as one, oversize clamps
  always_comb begin
    if (size_reg == 4'd0) begin
      n = CW'(1);
    end else if (size_reg > 4'(MAX_ORDER)) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(size_reg);
    end
  end

  assign k_last = (k + CW'(1)) == n;
  assign r_last = (r + CW'(1)) == n;
  assign diag   = (sel == MAT_WORK) && (k == c);

  assign rd_addr = {rd_sel, rd_row[RW-1:0], rd_col[RW-1:0]};
  assign wr_addr = {wr_sel, wr_row[RW-1:0], wr_col[RW-1:0]};

  assign last_of_matrix = (state == S_OSHOW) && r_last && k_last;

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    rd_sel    = sel;
    rd_row    = r;
    rd_col    = k;
    wr_sel    = sel;
    wr_row    = r;
    wr_col    = k;
    unique case (state)
      S_LOAD: begin
        in_stall     = 1'b0;
        cmd.wr_en    = in_valid;
        cmd.wr_src   = WS_INPUT;
        wr_sel       = MAT_WORK;
      end
      S_INIT: begin
        cmd.clr_flags = 1'b1;
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = (r == k) ? WS_ONE : WS_ZERO;
        wr_sel        = MAT_INV;
      end
      S_PRD: begin
        cmd.rd_en = 1'b1;
        rd_sel    = MAT_WORK;
        rd_row    = c;
        rd_col    = c;
      end
      S_PCHK: begin
        cmd.cap_piv  = 1'b1;
        cmd.set_sing = status.below_thr && ((c + CW'(1)) == n);
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        rd_sel    = MAT_WORK;
        rd_col    = c;
      end
      S_SCHK: begin
        cmd.set_sing = status.below_thr && r_last;
      end
      S_SWRA: begin
        cmd.rd_en = 1'b1;
      end
      S_SWRB: begin
        cmd.cap_a = 1'b1;
        cmd.rd_en = 1'b1;
        rd_row    = c;
      end
      S_SWWA: begin
        cmd.cap_b  = 1'b1;
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WS_A;
        wr_row     = c;
      end
      S_SWWB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WS_B;
      end
      S_NRD: begin
        cmd.rd_en = 1'b1;
        rd_row    = c;
      end
      S_NCHK: begin
        cmd.div_start = usable && !diag;
      end
      S_NDIV: begin
      end
      S_NWR: begin
        cmd.wr_en = 1'b1;
        wr_row    = c;
        if (diag) begin
          cmd.wr_src = WS_ONE;
        end else if (!usable) begin
          cmd.wr_src = WS_ZERO;
        end else begin
          cmd.wr_src = WS_DIV;
        end
      end
      S_MRD: begin
        cmd.rd_en = 1'b1;
        rd_sel    = MAT_WORK;
        rd_col    = c;
      end
      S_MCAP: begin
        cmd.cap_m = 1'b1;
      end
      S_ERV: begin
        cmd.rd_en = 1'b1;
      end
      S_ERP: begin
        cmd.cap_a = 1'b1;
        cmd.rd_en = 1'b1;
        rd_row    = c;
      end
      S_EMUL: begin
        cmd.mul = 1'b1;
      end
      S_EWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WS_ELIM;
      end
      S_ORD: begin
        cmd.rd_en = 1'b1;
        rd_sel    = MAT_INV;
      end
      S_OCAP: begin
        cmd.cap_out = 1'b1;
      end
      S_OSHOW: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      size_reg <= SIZE_RESET;
      c        <= '0;
      r        <= '0;
      k        <= '0;
      sel      <= MAT_WORK;
      back     <= 1'b0;
      usable   <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_MATRIX_SIZE) begin
        size_reg <= cfg_data[3:0];
      end
      unique case (state)
        S_LOAD: begin
          if (cfg_write && cfg_index == REG_MATRIX_SIZE) begin
            r <= '0;
            k <= '0;
          end else if (in_valid) begin
            if (!k_last) begin
              k <= k + CW'(1);
            end else begin
              k <= '0;
              if (!r_last) begin
                r <= r + CW'(1);
              end else begin
                r     <= '0;
                state <= S_INIT;
              end
            end
          end
        end
        S_INIT: begin
          if (!k_last) begin
            k <= k + CW'(1);
          end else begin
            k <= '0;
            if (!r_last) begin
              r <= r + CW'(1);
            end else begin
              r     <= '0;
              c     <= '0;
              state <= S_PRD;
            end
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (!status.below_thr) begin
            usable <= 1'b1;
            sel    <= MAT_WORK;
            k      <= c;
            state  <= S_NRD;
          end else if ((c + CW'(1)) != n) begin
            r     <= c + CW'(1);
            state <= S_SRD;
          end else begin
            usable <= 1'b0;
            sel    <= MAT_WORK;
            k      <= c;
            state  <= S_NRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (!status.below_thr) begin
            sel   <= MAT_WORK;
            k     <= '0;
            state <= S_SWRA;
          end else if (!r_last) begin
            r     <= r + CW'(1);
            state <= S_SRD;
          end else begin
            usable <= 1'b0;
            sel    <= MAT_WORK;
            k      <= c;
            state  <= S_NRD;
          end
        end
        S_SWRA: state <= S_SWRB;
        S_SWRB: state <= S_SWWA;
        S_SWWA: state <= S_SWWB;
        S_SWWB: begin
          if (!k_last) begin
            k     <= k + CW'(1);
            state <= S_SWRA;
          end else if (sel == MAT_WORK) begin
            sel   <= MAT_INV;
            k     <= '0;
            state <= S_SWRA;
          end else begin
            state <= S_PRD;
          end
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: state <= (usable && !diag) ? S_NDIV : S_NWR;
        S_NDIV: begin
          if (!status.div_busy) begin
            state <= S_NWR;
          end
        end
        S_NWR: begin
          if (!k_last) begin
            k     <= k + CW'(1);
            state <= S_NRD;
          end else if (sel == MAT_WORK) begin
            sel   <= MAT_INV;
            k     <= '0;
            state <= S_NRD;
          end else if ((c + CW'(1)) != n) begin
            r     <= c + CW'(1);
            back  <= 1'b0;
            state <= S_MRD;
          end else if (n != CW'(1)) begin
            c     <= n - CW'(1);
            r     <= n - CW'(2);
            back  <= 1'b1;
            state <= S_MRD;
          end else begin
            r     <= '0;
            k     <= '0;
            state <= S_ORD;
          end
        end
        S_MRD: state <= S_MCAP;
        S_MCAP: begin
          if (back) begin
            sel <= MAT_INV;
            k   <= '0;
          end else begin
            sel <= MAT_WORK;
            k   <= c + CW'(1);
          end
          state <= S_ERV;
        end
        S_ERV:  state <= S_ERP;
        S_ERP:  state <= S_EMUL;
        S_EMUL: state <= S_EWR;
        S_EWR: begin
          if (!k_last) begin
            k     <= k + CW'(1);
            state <= S_ERV;
          end else if (sel == MAT_WORK) begin
            sel   <= MAT_INV;
            k     <= '0;
            state <= S_ERV;
          end else if (!back) begin
            if (!r_last) begin
              r     <= r + CW'(1);
              state <= S_MRD;
            end else begin
              c     <= c + CW'(1);
              state <= S_PRD;
            end
          end else if (r != '0) begin
            r     <= r - CW'(1);
            state <= S_MRD;
          end else if (c > CW'(1)) begin
            c     <= c - CW'(1);
            r     <= c - CW'(2);
            state <= S_MRD;
          end else begin
            r     <= '0;
            k     <= '0;
            state <= S_ORD;
          end
        end
        S_ORD:  state <= S_OCAP;
        S_OCAP: state <= S_OSHOW;
        S_OSHOW: begin
          if (!out_stall) begin
            if (!k_last) begin
              k     <= k + CW'(1);
              state <= S_ORD;
            end else if (!r_last) begin
              k     <= '0;
              r     <= r + CW'(1);
              state <= S_ORD;
            end else begin
              r     <= '0;
              k     <= '0;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gauss_jordan_matrix_inverse_top.sv =====
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_top
// q16.16 matrix inverter by gauss-jordan elimination with row pivoting
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / element_value): n*n items, row-major,
//   one per cycle while loading; in_stall is high from the last element until
//   the last result item has been taken.
//   output channel (out_valid / out_stall): n*n result items, row-major, with
//   last_of_matrix on the final one; singular_found and saturated hold the
//   same value on every item of one matrix.
//   config port: cfg_write / cfg_index / cfg_data, index 0 is matrix_size
//   (restarts a load in progress), index 1 is small_threshold.
// sequence:
//   one shared memory port pair serves both matrices, so the inversion walks
//   element by element: it sets the identity, tests each pivot, swaps rows
//   when the pivot is too small, normalizes the pivot row through the
//   one-bit-a-cycle divider, eliminates the other rows by multiply-subtract
//   and then shows the result items. for n=8 the divider dominates.
// reset: rst is synchronous; it returns to loading with order 8, threshold 1
//   and the flags cleared. a stalled result holds its value until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gauss_jordan_matrix_inverse_top import gjmi_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration writes
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  // matrix elements in
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] element_value,
  // inverse elements out
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      inverse_value,
  output logic                    last_of_matrix,
  output logic                    singular_found,
  output logic                    saturated
);

  localparam int RW = $clog2(MAX_ORDER);
  localparam int AW = 2 * RW + 1;

  // command and status between sequencer and datapath
  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  gjmi_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .last_of_matrix (last_of_matrix),
    .cmd            (cmd),
    .status         (status),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr)
  );

  // both matrices, pivot test, multiply-subtract, divider, flags
  gjmi_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .element_value  (element_value),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .status         (status),
    .inverse_value  (inverse_value),
    .singular_found (singular_found),
    .saturated      (saturated)
  );

`include "gauss_jordan_matrix_inverse_top_assert.svh"

  // loading and readout never overlap
  `GJMI_ASSERT_NOW(a_no_overlap, !in_stall, !out_valid)
  // last flag only rides on a shown result
  `GJMI_ASSERT_NOW(a_last_valid, last_of_matrix, out_valid)
  // divider is never restarted while running
  `GJMI_ASSERT_NOW(a_div_idle, cmd.div_start, !status.div_busy)
  // after the last result is taken the block loads again
  `GJMI_ASSERT_NEXT(a_back_to_load, out_valid && !out_stall && last_of_matrix, !in_stall)

endmodule

`default_nettype wire
